[design/chr_pkg.sv]
// ----------------------------------------------------------------------------
// chr_pkg: shared types and constants of the consistent hash ring
// field widths, request and status codes, ring entry layout, stream widths
// ----------------------------------------------------------------------------
package chr_pkg;

    localparam int HASH_W   = 32;
    localparam int ID_W     = 20;
    localparam int OWNER_W  = 16;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // stream payload widths; the tdata widths are padded to whole bytes
    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = REQ_W;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1 + STATUS_W;

    typedef logic [REQ_W-1:0] t_req;
    localparam t_req REQ_ADD    = 2'd0;
    localparam t_req REQ_REMOVE = 2'd1;
    localparam t_req REQ_LOOKUP = 2'd2;

    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_FULL  = 2'd1;
    localparam t_status STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [HASH_W-1:0]  hash;
        logic [ID_W-1:0]    id;
        logic [OWNER_W-1:0] owner;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

[design/consistent_hash_ring.sv]
// ----------------------------------------------------------------------------
// consistent_hash_ring: sorted hash ring with virtual nodes
// keeps up to RING_DEPTH entries in ascending hash order in one ram and
// serves add, remove and lookup requests by scanning it one entry a cycle
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one request (add entry, remove server, lookup key); the
//   request kind travels in tuser. m_axis returns one result per request.
//   the cfg channel writes vnode_enable; write it only while the block idles.
// timing
//   a request is taken only in the idle state, then the ring is walked one
//   entry per cycle through the single ram read port. trivial cases (full,
//   empty, unknown kind) go straight to the done state without a walk.
// reset
//   i_rst_n low (synchronous) empties the ring and clears vnode_enable; ram
//   contents are left as they are, only entries below the count are read.
// stall
//   the result sits in an output register; the next request is taken while
//   it waits, but a finished result holds the sequencer until the register
//   is free.
// ----------------------------------------------------------------------------
module consistent_hash_ring #(
    parameter int RING_DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration: bit 0 is vnode_enable
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_data,
    // requests
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // entry_id [19:0], entry_hash [51:20], owner_id [67:52], key_hash [99:68]
    input  logic [chr_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // req_type [1:0]
    input  logic [chr_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    // results
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // found_owner [19:0], entry_count [26:20]
    output logic [chr_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // found_valid [0], status [2:1]
    output logic [chr_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

    import chr_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(RING_DEPTH);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_AZERO = 7'b0000010,   // add: entry 0 arrives, start downward walk
        S_ASCAN = 7'b0000100,   // add: shift larger entries up by one
        S_AINS  = 7'b0001000,   // add: new entry goes to position 0
        S_LSCAN = 7'b0010000,   // lookup: upward search
        S_RSCAN = 7'b0100000,   // remove: upward compaction
        S_DONE  = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic                r_vnode;
    t_entry              r_new;          // entry to add, owner doubles as remove key
    logic [HASH_W-1:0]   r_key;
    logic [AW-1:0]       r_pa, n_pa;     // address of the entry now on the ram output
    logic [AW-1:0]       r_wp, n_wp;     // compaction write pointer
    logic                r_hit, n_hit;
    logic [OWNER_W-1:0]  r_succ, n_succ;
    logic [ID_W-1:0]     r_first, n_first;

    logic [ID_W-1:0]     r_res_owner, n_res_owner;
    logic                r_res_valid, n_res_valid;
    t_status             r_res_status, n_res_status;

    logic                r_m_valid, n_m_valid;
    logic [ID_W-1:0]     r_m_owner, n_m_owner;
    logic                r_m_found, n_m_found;
    t_status             r_m_status, n_m_status;
    logic [COUNT_W-1:0]  r_m_count, n_m_count;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    t_entry              ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    t_entry              rd_entry;
    t_entry              in_entry;
    t_req                in_req;
    logic                s_accept;
    logic                last;
    logic                drop;
    logic [ID_W-1:0]     lkp_sel;

    chr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry       = t_entry'(ram_rdata);
    assign in_entry.hash  = s_axis_tdata[51:20];
    assign in_entry.id    = s_axis_tdata[19:0];
    assign in_entry.owner = s_axis_tdata[67:52];
    assign in_req         = t_req'(s_axis_tuser);

    assign s_axis_tready  = (r_state == S_IDLE);
    assign s_accept       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready    = 1'b1;

    assign m_axis_tvalid  = r_m_valid;
    assign m_axis_tdata   = {{(M_TDATA_W - ID_W - COUNT_W){1'b0}}, r_m_count, r_m_owner};
    assign m_axis_tuser   = {r_m_status, r_m_found};

    // scan helpers
    assign last    = (r_pa == AW'(r_count - CW'(1)));
    assign lkp_sel = r_vnode ? ID_W'(rd_entry.owner) : rd_entry.id;
    // vnodes on: every entry of the owner; off: first entry with that id
    assign drop    = r_vnode ? (rd_entry.owner == r_new.owner)
                             : (!r_hit && (rd_entry.id == ID_W'(r_new.owner)));

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pa         = r_pa;
        n_wp         = r_wp;
        n_hit        = r_hit;
        n_succ       = r_succ;
        n_first      = r_first;
        n_res_owner  = r_res_owner;
        n_res_valid  = r_res_valid;
        n_res_status = r_res_status;
        n_m_valid    = r_m_valid;
        n_m_owner    = r_m_owner;
        n_m_found    = r_m_found;
        n_m_status   = r_m_status;
        n_m_count    = r_m_count;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = r_new;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                // entry 0 is fetched ahead of every request
                ram_re = 1'b1;
                if (s_accept) begin
                    n_res_owner  = '0;
                    n_res_valid  = 1'b0;
                    n_res_status = STAT_OK;
                    n_pa         = '0;
                    n_wp         = '0;
                    n_hit        = 1'b0;
                    n_state      = S_DONE;
                    case (in_req)
                        REQ_ADD: begin
                            if (r_count >= FULL_COUNT) begin
                                n_res_status = STAT_FULL;
                            end else if (r_count == '0) begin
                                ram_we    = 1'b1;
                                ram_wdata = in_entry;
                                n_count   = CW'(1);
                            end else begin
                                n_state = S_AZERO;
                            end
                        end
                        REQ_REMOVE: begin
                            if (r_count == '0) begin
                                n_res_status = STAT_EMPTY;
                            end else begin
                                n_state = S_RSCAN;
                            end
                        end
                        REQ_LOOKUP: begin
                            if (r_count == '0) begin
                                n_res_status = STAT_EMPTY;
                            end else begin
                                n_state = S_LSCAN;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_AZERO: begin
                // wrap successor in case nothing is larger
                n_succ    = rd_entry.owner;
                ram_re    = 1'b1;
                ram_raddr = AW'(r_count - CW'(1));
                n_pa      = AW'(r_count - CW'(1));
                n_state   = S_ASCAN;
            end

            S_ASCAN: begin
                ram_we    = 1'b1;
                ram_waddr = r_pa + AW'(1);
                if (r_new.hash < rd_entry.hash) begin
                    ram_wdata = rd_entry;
                    n_succ    = rd_entry.owner;
                    if (r_pa == '0) begin
                        n_state = S_AINS;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_pa - AW'(1);
                        n_pa      = r_pa - AW'(1);
                    end
                end else begin
                    ram_wdata   = r_new;
                    n_count     = r_count + CW'(1);
                    n_res_owner = ID_W'(r_succ);
                    n_res_valid = 1'b1;
                    n_state     = S_DONE;
                end
            end

            S_AINS: begin
                ram_we      = 1'b1;
                ram_wdata   = r_new;
                n_count     = r_count + CW'(1);
                n_res_owner = ID_W'(r_succ);
                n_res_valid = 1'b1;
                n_state     = S_DONE;
            end

            S_LSCAN: begin
                if (r_pa == '0) begin
                    n_first = lkp_sel;
                end
                if (r_key <= rd_entry.hash) begin
                    n_res_owner = lkp_sel;
                    n_res_valid = 1'b1;
                    n_state     = S_DONE;
                end else if (last) begin
                    // no entry at or above the key: wrap to entry 0
                    n_res_owner = (r_pa == '0) ? lkp_sel : r_first;
                    n_res_valid = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_pa + AW'(1);
                    n_pa      = r_pa + AW'(1);
                end
            end

            S_RSCAN: begin
                if (drop) begin
                    n_hit = 1'b1;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wp;
                    ram_wdata = rd_entry;
                    n_wp      = r_wp + AW'(1);
                end
                if (last) begin
                    n_count      = CW'(r_wp) + (drop ? CW'(0) : CW'(1));
                    n_res_status = (r_hit || drop) ? STAT_OK : STAT_EMPTY;
                    n_state      = S_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_pa + AW'(1);
                    n_pa      = r_pa + AW'(1);
                end
            end

            S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_owner  = r_res_owner;
                    n_m_found  = r_res_valid;
                    n_m_status = r_res_status;
                    n_m_count  = COUNT_W'(r_count);
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_vnode   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_vnode <= i_cfg_data;
            end
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_new <= in_entry;
            r_key <= s_axis_tdata[99:68];
        end
        r_pa         <= n_pa;
        r_wp         <= n_wp;
        r_hit        <= n_hit;
        r_succ       <= n_succ;
        r_first      <= n_first;
        r_res_owner  <= n_res_owner;
        r_res_valid  <= n_res_valid;
        r_res_status <= n_res_status;
        r_m_owner    <= n_m_owner;
        r_m_found    <= n_m_found;
        r_m_status   <= n_m_status;
        r_m_count    <= n_m_count;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("ring count above depth");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ASCAN || r_state == S_LSCAN || r_state == S_RSCAN)
            |-> (CW'(r_pa) < r_count))
        else $error("scan address outside stored entries");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RSCAN) |-> (r_wp <= r_pa))
        else $error("compaction write pointer passed read pointer");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside done state");
`endif

endmodule

[design/chr_ram.sv]
// ----------------------------------------------------------------------------
// chr_ram: generic single-write, single-read ram
// one write port and one read port, read data registered
// ----------------------------------------------------------------------------
module chr_ram #(
    parameter int WIDTH = 68,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the consistent hash ring
// drives add, remove and lookup requests on the request stream, mirrors the
// sorted ring in a scoreboard and compares every result field by field
// ----------------------------------------------------------------------------
module tb_top;
    import chr_pkg::*;

    localparam int    RING_DEPTH     = 64;
    localparam int    REPLICA_STRIDE = 100000;
    localparam t_req  REQ_UNUSED     = 2'd3;
    localparam int    WATCHDOG_LIMIT = 20000;
    localparam int    DRAIN_CYCLES   = RING_DEPTH + 16;
    localparam int    HOLD_CYCLES    = 400;
    localparam int    HOLD_AT_RESULT = 120;
    localparam int    PHASE_ITEMS    = 70;
    localparam int    N_PHASES       = 8;

    // traffic mixes of the random phases
    localparam int MIX_FILL   = 0;
    localparam int MIX_CHURN  = 1;
    localparam int MIX_SHRINK = 2;

    typedef struct {
        t_req              kind;
        logic [ID_W-1:0]    entry_id;
        logic [HASH_W-1:0]  entry_hash;
        logic [OWNER_W-1:0] owner_id;
        logic [HASH_W-1:0]  key_hash;
    } t_ring_req;

    typedef struct {
        logic [ID_W-1:0]    found_owner;
        logic               found_valid;
        t_status            status;
        logic [COUNT_W-1:0] entry_count;
    } t_ring_res;

    // mirror of the sorted ring and the queue of results still to come
    class ring_scoreboard;
        logic [HASH_W-1:0]  hash_q[$];
        logic [ID_W-1:0]    id_q[$];
        logic [OWNER_W-1:0] owner_q[$];
        logic               vnode;
        t_ring_res          exp_q[$];
        int                 n_err;
        int                 n_checked;

        function void set_vnode(logic v);
            vnode = v;
        endfunction

        function int pending();
            return exp_q.size();
        endfunction

        function void drop(int pos);
            hash_q.delete(pos);
            id_q.delete(pos);
            owner_q.delete(pos);
        endfunction

        // apply one accepted request to the mirror and queue its result
        function void note_req(t_ring_req r);
            t_ring_res res;
            int        pos;
            int        n;
            bit        hit;
            int        i;
            res = '{found_owner: '0, found_valid: 1'b0, status: STAT_OK, entry_count: '0};
            n   = hash_q.size();
            hit = 1'b0;
            case (r.kind)
                REQ_ADD: begin
                    if (n >= RING_DEPTH) begin
                        res.status = STAT_FULL;
                    end else begin
                        pos = n;
                        for (i = 0; i < n; i++) begin
                            if (r.entry_hash < hash_q[i]) begin
                                pos = i;
                                break;
                            end
                        end
                        // successor wraps to the first entry
                        if (n > 0) begin
                            res.found_owner = ID_W'(owner_q[(pos < n) ? pos : 0]);
                            res.found_valid = 1'b1;
                        end
                        hash_q.insert(pos, r.entry_hash);
                        id_q.insert(pos, r.entry_id);
                        owner_q.insert(pos, r.owner_id);
                    end
                end
                REQ_REMOVE: begin
                    if (vnode) begin
                        i = 0;
                        while (i < hash_q.size()) begin
                            if (owner_q[i] == r.owner_id) begin
                                drop(i);
                                hit = 1'b1;
                            end else begin
                                i++;
                            end
                        end
                    end else begin
                        for (i = 0; i < n; i++) begin
                            if (id_q[i] == ID_W'(r.owner_id)) begin
                                drop(i);
                                hit = 1'b1;
                                break;
                            end
                        end
                    end
                    res.status = hit ? STAT_OK : STAT_EMPTY;
                end
                REQ_LOOKUP: begin
                    if (n == 0) begin
                        res.status = STAT_EMPTY;
                    end else begin
                        pos = 0;
                        for (i = 0; i < n; i++) begin
                            if (r.key_hash <= hash_q[i]) begin
                                pos = i;
                                break;
                            end
                        end
                        res.found_owner = vnode ? ID_W'(owner_q[pos]) : id_q[pos];
                        res.found_valid = 1'b1;
                    end
                end
                default: ;
            endcase
            res.entry_count = COUNT_W'(hash_q.size());
            exp_q.push_back(res);
        endfunction

        function void check_result(t_ring_res got);
            t_ring_res want;
            n_checked++;
            if (exp_q.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("result %0d arrived with none expected", n_checked);
                return;
            end
            want = exp_q.pop_front();
            if (got.found_owner !== want.found_owner || got.found_valid !== want.found_valid ||
                got.status !== want.status || got.entry_count !== want.entry_count) begin
                n_err++;
                if (n_err <= 10) begin
                    $display("result %0d: expected owner %h valid %b status %0d count %0d",
                             n_checked, want.found_owner, want.found_valid, want.status,
                             want.entry_count);
                    $display("    got owner %h valid %b status %0d count %0d",
                             got.found_owner, got.found_valid, got.status,
                             got.entry_count);
                end
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic                   i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic [S_TUSER_W-1:0]   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [M_TUSER_W-1:0]   m_axis_tuser;

    ring_scoreboard ring_sb = new();
    logic [OWNER_W-1:0] owner_pool[6];
    bit calm;

    consistent_hash_ring #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones, none in calm stretches
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 100);
    endfunction

    // hashes cluster on the extremes and around stored positions
    function automatic logic [HASH_W-1:0] pick_hash();
        int n;
        int r;
        logic [HASH_W-1:0] h;
        n = ring_sb.hash_q.size();
        r = $urandom_range(0, 9);
        if (n > 0)
            h = ring_sb.hash_q[$urandom_range(0, n - 1)];
        else
            h = $urandom();
        case (r)
            0:       return '0;
            1:       return '1;
            2, 3:    return h;
            4:       return h + 1'b1;
            5:       return h - 1'b1;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_ring_req make_req(int mix);
        t_ring_req r;
        int        roll;
        int        n;
        int        k;
        int        add_pct;
        int        rem_pct;
        n = ring_sb.hash_q.size();
        case (mix)
            MIX_FILL:  begin add_pct = 85; rem_pct = 5;  end
            MIX_CHURN: begin add_pct = 40; rem_pct = 25; end
            default:   begin add_pct = 20; rem_pct = 45; end
        endcase
        r.entry_id   = ID_W'($urandom());
        r.entry_hash = $urandom();
        r.owner_id   = OWNER_W'($urandom());
        r.key_hash   = $urandom();
        roll = $urandom_range(0, 99);
        if (roll < add_pct) begin
            r.kind       = REQ_ADD;
            r.entry_hash = pick_hash();
            if ($urandom_range(0, 4) != 0)
                r.owner_id = owner_pool[$urandom_range(0, 5)];
            if ($urandom_range(0, 9) < 7) begin
                // replica ids sit a fixed stride apart; most are the server itself
                k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
                r.entry_id = ID_W'(r.owner_id) + ID_W'(k * REPLICA_STRIDE);
            end
        end else if (roll < add_pct + rem_pct) begin
            r.kind = REQ_REMOVE;
            if (n > 0 && $urandom_range(0, 9) < 7) begin
                k = $urandom_range(0, n - 1);
                r.owner_id = ring_sb.vnode ? ring_sb.owner_q[k] : ring_sb.id_q[k][OWNER_W-1:0];
            end else if ($urandom_range(0, 1) == 0) begin
                r.owner_id = owner_pool[$urandom_range(0, 5)];
            end
        end else if (roll < 98) begin
            r.kind     = REQ_LOOKUP;
            r.key_hash = pick_hash();
        end else begin
            r.kind = REQ_UNUSED;
        end
        return r;
    endfunction

    // offer one request and wait until the ring takes it
    task automatic push_req(input t_ring_req r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, r.key_hash, r.owner_id, r.entry_hash, r.entry_id};
        s_axis_tuser  <= r.kind;
        do @(posedge i_clk); while (!s_axis_tready);
        ring_sb.note_req(r);
    endtask

    task automatic send_fields(input t_req kind, input logic [ID_W-1:0] id,
                               input logic [HASH_W-1:0] h, input logic [OWNER_W-1:0] own,
                               input logic [HASH_W-1:0] key);
        t_ring_req r;
        r = '{kind: kind, entry_id: id, entry_hash: h, owner_id: own, key_hash: key};
        push_req(r);
    endtask

    // config writes only once every result is back
    task automatic write_vnode(input logic v);
        s_axis_tvalid <= 1'b0;
        while (ring_sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        ring_sb.set_vnode(v);
        i_cfg_valid <= 1'b0;
    endtask

    // result side: random stalls plus one long hold so the input backs up
    initial begin
        int stall_left;
        int hold_left;
        bit held;
        t_ring_res got;
        stall_left = 0;
        hold_left  = 0;
        held       = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.found_owner = m_axis_tdata[ID_W-1:0];
                got.entry_count = m_axis_tdata[ID_W +: COUNT_W];
                got.found_valid = m_axis_tuser[0];
                got.status      = m_axis_tuser[1 +: STATUS_W];
                ring_sb.check_result(got);
            end
            if (!held && ring_sb.n_checked >= HOLD_AT_RESULT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                m_axis_tready <= (stall_left == 0) && i_rst_n;
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        int  p;
        int  mix;
        bit  flip;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        calm = 1'b0;
        owner_pool[0] = '0;
        owner_pool[1] = '1;
        for (p = 2; p < 6; p++)
            owner_pool[p] = OWNER_W'($urandom());
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty ring, ordering of equal hashes, wrap-around, exact removes
        write_vnode(1'b0);
        send_fields(REQ_LOOKUP, 20'd0, 32'd0, 16'd0, 32'h8000_0000);
        send_fields(REQ_REMOVE, 20'd0, 32'd0, 16'd5, 32'd0);
        send_fields(REQ_UNUSED, 20'd0, 32'd0, 16'd0, 32'd0);
        send_fields(REQ_ADD, 20'd5, 32'd1000, 16'd7, 32'd0);
        send_fields(REQ_ADD, 20'd6, 32'd1000, 16'd8, 32'd0);
        send_fields(REQ_LOOKUP, 20'd0, 32'd0, 16'd0, 32'd2000);
        send_fields(REQ_ADD, 20'd0, 32'd0, 16'd0, 32'd0);
        send_fields(REQ_ADD, 20'hFFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
        send_fields(REQ_LOOKUP, 20'd0, 32'd0, 16'd0, 32'd0);
        send_fields(REQ_LOOKUP, 20'd0, 32'd0, 16'd0, 32'd1000);
        send_fields(REQ_LOOKUP, 20'd0, 32'd0, 16'd0, 32'd1001);
        send_fields(REQ_LOOKUP, 20'd0, 32'd0, 16'd0, 32'hFFFF_FFFF);
        send_fields(REQ_REMOVE, 20'd0, 32'd0, 16'd6, 32'd0);
        send_fields(REQ_REMOVE, 20'd0, 32'd0, 16'd6, 32'd0);
        send_fields(REQ_UNUSED, 20'hFFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);

        // directed with virtual nodes: whole-owner removes
        write_vnode(1'b1);
        send_fields(REQ_ADD, 20'h12345, 32'd500, 16'd7, 32'd0);
        send_fields(REQ_LOOKUP, 20'd0, 32'd0, 16'd0, 32'd400);
        send_fields(REQ_LOOKUP, 20'd0, 32'd0, 16'd0, 32'hFFFF_FFFF);
        send_fields(REQ_REMOVE, 20'd0, 32'd0, 16'd7, 32'd0);
        send_fields(REQ_REMOVE, 20'd0, 32'd0, 16'd7, 32'd0);
        send_fields(REQ_REMOVE, 20'd0, 32'd0, 16'd0, 32'd0);
        send_fields(REQ_REMOVE, 20'd0, 32'd0, 16'hFFFF, 32'd0);
        send_fields(REQ_LOOKUP, 20'd0, 32'd0, 16'd0, 32'd0);

        // random phases: fill to full, churn, drain, under both settings
        flip = 1'($urandom_range(0, 1));
        for (p = 0; p < N_PHASES; p++) begin
            case (p % 4)
                0, 1:    mix = MIX_FILL;
                2:       mix = MIX_CHURN;
                default: mix = MIX_SHRINK;
            endcase
            write_vnode(p[0] ^ flip);
            calm = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) push_req(make_req(mix));
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (ring_sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (ring_sb.n_err == 0 && ring_sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
